>>> design/hbp_pkg.sv
package hbp_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHOOSER_BITS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GSHARE_BITS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HISTORY_BITS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BIMODAL_BITS = 3'd4;

  // Predictor modes (3 behaves as hybrid)
  localparam logic [1:0] MODE_BIMODAL = 2'd0;
  localparam logic [1:0] MODE_GSHARE  = 2'd1;
  localparam logic [1:0] MODE_HYBRID  = 2'd2;

  // Request types
  localparam logic REQ_RESOLVE = 1'b0;
  localparam logic REQ_READ    = 1'b1;

  // Table select codes for reads
  localparam logic [1:0] TSEL_CHOOSER = 2'd0;
  localparam logic [1:0] TSEL_GSHARE  = 2'd1;
  localparam logic [1:0] TSEL_BIMODAL = 2'd2;

  // Reset values of table entries
  localparam logic [2:0] CTR_INIT = 3'd4;
  localparam logic [1:0] CHS_INIT = 2'd1;

  // Global history length in bits
  localparam int unsigned HIST_W = 14;

  typedef struct packed {
    logic [3:0] bimodal_index_bits;
    logic [3:0] history_bits;
    logic [3:0] gshare_index_bits;
    logic [3:0] chooser_index_bits;
    logic [1:0] mode;
  } hbp_cfg_t;

  typedef struct packed {
    logic        req_type;
    logic [31:0] pc;
    logic        taken;
    logic [1:0]  table_select;
    logic [13:0] entry_index;
  } hbp_in_t;

  typedef struct packed {
    logic        pred_taken;
    logic        mispredicted;
    logic        used_gshare;
    logic [31:0] prediction_count;
    logic [31:0] mispredict_count;
    logic [2:0]  read_value;
  } hbp_out_t;

  // Classification of a queued word
  typedef enum logic [1:0] {
    KIND_READ    = 2'd0,
    KIND_BIMODAL = 2'd1,
    KIND_GSHARE  = 2'd2,
    KIND_HYBRID  = 2'd3
  } hbp_kind_t;

  typedef struct packed {
    hbp_kind_t  kind;
    logic       taken;
    logic [1:0] table_select;
  } hbp_ctl_t;

endpackage

>>> design/hbp_queue.sv
module hbp_queue #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         not_empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   cnt_r, cnt_nxt;

  assign full      = (cnt_r == (PW+1)'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign rdata     = mem_r[rd_ptr_r];

  // pointer wrap assumes a power-of-two depth
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

>>> design/hbp_front.sv
module hbp_front #(
  parameter int unsigned CB = 14,
  parameter int unsigned GB = 14,
  parameter int unsigned BB = 14
) (
  input  logic             clk,
  input  logic             rst_n,
  input  hbp_pkg::hbp_cfg_t cfg,
  input  logic             in_valid,
  input  hbp_pkg::hbp_in_t in_data,
  output logic             in_stall,
  input  logic             q_full,
  input  logic             clr_busy,
  output logic             push,
  output hbp_pkg::hbp_ctl_t ctl,
  output logic [CB-1:0]    ci,
  output logic [GB-1:0]    gi,
  output logic [BB-1:0]    bi
);

  import hbp_pkg::*;

  localparam logic [4:0] CB_MAX = 5'(CB);
  localparam logic [4:0] GB_MAX = 5'(GB);
  localparam logic [4:0] BB_MAX = 5'(BB);

  function automatic logic [4:0] clamp_bits(logic [3:0] v, logic [4:0] mx);
    logic [4:0] w;
    w = {1'b0, v};
    if (v == 4'd0) begin
      return 5'd1;
    end else if (w > mx) begin
      return mx;
    end
    return w;
  endfunction

  logic [HIST_W-1:0] hist_r, hist_nxt;
  logic [HIST_W-1:0] hmask, hist_m;
  logic [4:0]        k, m1, m2, hb, n;
  logic [29:0]       word;
  logic [CB-1:0]     ch_mask;
  logic [GB-1:0]     gs_mask;
  logic [BB-1:0]     bm_mask;
  logic              is_read;

  assign in_stall = q_full | clr_busy;
  assign push     = in_valid & ~in_stall;
  assign is_read  = (in_data.req_type == REQ_READ);
  assign word     = in_data.pc[31:2];

  assign k  = clamp_bits(cfg.chooser_index_bits, CB_MAX);
  assign m1 = clamp_bits(cfg.gshare_index_bits, GB_MAX);
  assign m2 = clamp_bits(cfg.bimodal_index_bits, BB_MAX);
  assign hb = {1'b0, cfg.history_bits};
  assign n  = (hb > m1) ? m1 : hb;

  always_comb begin
    for (int i = 0; i < CB; i++) ch_mask[i] = (5'(i) < k);
    for (int i = 0; i < GB; i++) gs_mask[i] = (5'(i) < m1);
    for (int i = 0; i < BB; i++) bm_mask[i] = (5'(i) < m2);
    for (int i = 0; i < HIST_W; i++) hmask[i] = (5'(i) < n);
  end

  assign hist_m = hist_r & hmask;

  // shift right, outcome enters at bit n-1
  always_comb begin
    for (int i = 0; i < HIST_W; i++) begin
      if (5'(i) + 5'd1 == n) begin
        hist_nxt[i] = in_data.taken;
      end else if (i + 1 < HIST_W) begin
        hist_nxt[i] = hist_m[(i + 1) % HIST_W];
      end else begin
        hist_nxt[i] = 1'b0;
      end
    end
  end

  always_comb begin
    if (is_read) begin
      ci = CB'(in_data.entry_index);
      gi = GB'(in_data.entry_index);
      bi = BB'(in_data.entry_index);
    end else begin
      ci = word[CB-1:0] & ch_mask;
      gi = (word[GB-1:0] & gs_mask) ^ GB'(hist_m);
      bi = word[BB-1:0] & bm_mask;
    end
  end

  always_comb begin
    ctl.taken        = in_data.taken;
    ctl.table_select = in_data.table_select;
    if (is_read) begin
      ctl.kind = KIND_READ;
    end else begin
      case (cfg.mode)
        MODE_BIMODAL: ctl.kind = KIND_BIMODAL;
        MODE_GSHARE:  ctl.kind = KIND_GSHARE;
        default:      ctl.kind = KIND_HYBRID;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
    end else if (push && !is_read && cfg.mode != MODE_BIMODAL) begin
      hist_r <= hist_nxt;
    end
  end

endmodule

>>> design/hbp_back.sv
module hbp_back #(
  parameter int unsigned CB = 14,
  parameter int unsigned GB = 14,
  parameter int unsigned BB = 14
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  hbp_pkg::hbp_ctl_t q_ctl,
  input  logic [CB-1:0]     q_ci,
  input  logic [GB-1:0]     q_gi,
  input  logic [BB-1:0]     q_bi,
  output logic              q_pop,
  output logic              clr_busy,
  output logic              out_valid,
  input  logic              out_stall,
  output hbp_pkg::hbp_out_t out_data
);

  import hbp_pkg::*;

  localparam int unsigned CG_W  = (CB > GB) ? CB : GB;
  localparam int unsigned CLR_W = (CG_W > BB) ? CG_W : BB;

  function automatic logic [2:0] train3(logic [2:0] c, logic t);
    if (t) begin
      return (c != 3'd7) ? c + 3'd1 : c;
    end
    return (c != 3'd0) ? c - 3'd1 : c;
  endfunction

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  // tables
  logic [1:0] ch_mem [0:(1<<CB)-1];
  logic [2:0] gs_mem [0:(1<<GB)-1];
  logic [2:0] bm_mem [0:(1<<BB)-1];

  // clearing sweep
  logic             clr_busy_r;
  logic [CLR_W-1:0] clr_idx_r;

  // execute stage
  logic          e_valid_r, e_valid_nxt;
  hbp_ctl_t      e_ctl_r;
  logic [CB-1:0] e_ci_r;
  logic [GB-1:0] e_gi_r;
  logic [BB-1:0] e_bi_r;
  logic [1:0]    ch_rd_r;
  logic [2:0]    gs_rd_r, bm_rd_r;

  // last write per table, for read-during-write bypass
  logic          ch_wv_r, gs_wv_r, bm_wv_r;
  logic [CB-1:0] ch_wa_r;
  logic [GB-1:0] gs_wa_r;
  logic [BB-1:0] bm_wa_r;
  logic [1:0]    ch_wd_r;
  logic [2:0]    gs_wd_r, bm_wd_r;

  logic [31:0] tot_r, tot_nxt, miss_cnt_r, miss_cnt_nxt;
  logic        out_valid_r, out_valid_nxt;
  hbp_out_t    out_data_r, res;

  logic       e_fire, resolve, used_g, gp, bp, pred, miss, gc, bc;
  logic [1:0] ch_v, ch_new;
  logic [2:0] gs_v, bm_v, gs_new, bm_new, rv;
  logic       ch_upd, gs_upd, bm_upd;
  logic       ch_we, gs_we, bm_we;
  logic [CB-1:0] ch_wa;
  logic [GB-1:0] gs_wa;
  logic [BB-1:0] bm_wa;
  logic [1:0]    ch_wd;
  logic [2:0]    gs_wd, bm_wd;

  assign clr_busy  = clr_busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign e_fire      = e_valid_r & (~out_valid_r | ~out_stall);
  assign q_pop       = q_valid & ~clr_busy_r & (~e_valid_r | e_fire);
  assign e_valid_nxt = q_pop | (e_valid_r & ~e_fire);

  // operands with bypass of the newest write
  assign ch_v = (ch_wv_r && ch_wa_r == e_ci_r) ? ch_wd_r : ch_rd_r;
  assign gs_v = (gs_wv_r && gs_wa_r == e_gi_r) ? gs_wd_r : gs_rd_r;
  assign bm_v = (bm_wv_r && bm_wa_r == e_bi_r) ? bm_wd_r : bm_rd_r;

  assign resolve = (e_ctl_r.kind != KIND_READ);
  assign gp      = gs_v[2];
  assign bp      = bm_v[2];

  always_comb begin
    case (e_ctl_r.kind)
      KIND_GSHARE: used_g = 1'b1;
      KIND_HYBRID: used_g = ch_v[1];
      default:     used_g = 1'b0;
    endcase
  end

  assign pred   = used_g ? gp : bp;
  assign miss   = pred ^ e_ctl_r.taken;
  assign gs_new = train3(gs_v, e_ctl_r.taken);
  assign bm_new = train3(bm_v, e_ctl_r.taken);
  assign gc     = (gp == e_ctl_r.taken);
  assign bc     = (bp == e_ctl_r.taken);

  // chooser drifts toward the predictor that alone was right
  always_comb begin
    ch_new = ch_v;
    if (gc && !bc && ch_v != 2'd3) begin
      ch_new = ch_v + 2'd1;
    end else if (!gc && bc && ch_v != 2'd0) begin
      ch_new = ch_v - 2'd1;
    end
  end

  always_comb begin
    case (e_ctl_r.table_select)
      TSEL_CHOOSER: rv = {1'b0, ch_v};
      TSEL_GSHARE:  rv = gs_v;
      TSEL_BIMODAL: rv = bm_v;
      default:      rv = 3'd0;
    endcase
  end

  assign ch_upd = e_fire & (e_ctl_r.kind == KIND_HYBRID);
  assign gs_upd = e_fire & resolve & used_g;
  assign bm_upd = e_fire & resolve & ~used_g;

  assign tot_nxt      = resolve ? sat_inc(tot_r) : tot_r;
  assign miss_cnt_nxt = (resolve && miss) ? sat_inc(miss_cnt_r) : miss_cnt_r;

  always_comb begin
    res.pred_taken       = resolve & pred;
    res.mispredicted     = resolve & miss;
    res.used_gshare      = resolve & used_g;
    res.prediction_count = tot_nxt;
    res.mispredict_count = miss_cnt_nxt;
    res.read_value       = resolve ? 3'd0 : rv;
  end

  // write port: clearing sweep or training
  assign ch_we = clr_busy_r | ch_upd;
  assign gs_we = clr_busy_r | gs_upd;
  assign bm_we = clr_busy_r | bm_upd;
  assign ch_wa = clr_busy_r ? CB'(clr_idx_r) : e_ci_r;
  assign gs_wa = clr_busy_r ? GB'(clr_idx_r) : e_gi_r;
  assign bm_wa = clr_busy_r ? BB'(clr_idx_r) : e_bi_r;
  assign ch_wd = clr_busy_r ? CHS_INIT : ch_new;
  assign gs_wd = clr_busy_r ? CTR_INIT : gs_new;
  assign bm_wd = clr_busy_r ? CTR_INIT : bm_new;

  assign out_valid_nxt = e_fire | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (ch_we) ch_mem[ch_wa] <= ch_wd;
    if (q_pop) ch_rd_r <= ch_mem[q_ci];
  end

  always_ff @(posedge clk) begin
    if (gs_we) gs_mem[gs_wa] <= gs_wd;
    if (q_pop) gs_rd_r <= gs_mem[q_gi];
  end

  always_ff @(posedge clk) begin
    if (bm_we) bm_mem[bm_wa] <= bm_wd;
    if (q_pop) bm_rd_r <= bm_mem[q_bi];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r  <= 1'b1;
      clr_idx_r   <= '0;
      e_valid_r   <= 1'b0;
      ch_wv_r     <= 1'b0;
      gs_wv_r     <= 1'b0;
      bm_wv_r     <= 1'b0;
      tot_r       <= '0;
      miss_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_idx_r <= clr_idx_r + 1'b1;
        if (clr_idx_r == '1) clr_busy_r <= 1'b0;
      end
      e_valid_r   <= e_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (ch_upd) ch_wv_r <= 1'b1;
      if (gs_upd) gs_wv_r <= 1'b1;
      if (bm_upd) bm_wv_r <= 1'b1;
      if (e_fire) begin
        tot_r      <= tot_nxt;
        miss_cnt_r <= miss_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      e_ctl_r <= q_ctl;
      e_ci_r  <= q_ci;
      e_gi_r  <= q_gi;
      e_bi_r  <= q_bi;
    end
    if (ch_upd) begin
      ch_wa_r <= e_ci_r;
      ch_wd_r <= ch_new;
    end
    if (gs_upd) begin
      gs_wa_r <= e_gi_r;
      gs_wd_r <= gs_new;
    end
    if (bm_upd) begin
      bm_wa_r <= e_bi_r;
      bm_wd_r <= bm_new;
    end
    if (e_fire) begin
      out_data_r <= res;
    end
  end

endmodule

>>> design/hybrid_branch_predictor_unit.sv
// Hybrid gshare/bimodal branch predictor. Each input word either resolves a
// branch (predict from the bimodal, gshare or chooser-selected table, then
// train) or reads back one table entry; every word yields exactly one result
// word. Sustained rate is one word per cycle while the output is not stalled;
// out_valid rises when the word reaches the output register, past the queue
// and the execute stage. The rate is set by the per-table read-modify-write in
// the back end: tables are read when a word leaves the queue, written when it
// leaves the execute stage, and a last-write bypass per table covers
// back-to-back hits on the same entry. After reset the back end sweeps all
// 2**max(CHOOSER_BITS_MAX, GSHARE_BITS_MAX, BIMODAL_BITS_MAX) entries (16384 with
// the defaults) to their initial values, one entry per cycle; in_stall stays high
// until the sweep ends, but config writes are taken. Config registers may only be written while the block is idle.
module hybrid_branch_predictor_unit #(
  parameter int unsigned CHOOSER_BITS_MAX = 14,
  parameter int unsigned GSHARE_BITS_MAX  = 14,
  parameter int unsigned BIMODAL_BITS_MAX = 14
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // config write port
  input  logic                                cfg_we,
  input  logic [hbp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hbp_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  // request channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  hbp_pkg::hbp_in_t                    in_data,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output hbp_pkg::hbp_out_t                   out_data
);

  import hbp_pkg::*;

  localparam int unsigned CB    = CHOOSER_BITS_MAX;
  localparam int unsigned GB    = GSHARE_BITS_MAX;
  localparam int unsigned BB    = BIMODAL_BITS_MAX;
  localparam int unsigned CTL_W = $bits(hbp_ctl_t);
  localparam int unsigned QW    = CTL_W + CB + GB + BB;
  localparam int unsigned QDEPTH = 2;

  // config registers
  hbp_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode               <= MODE_HYBRID;
      cfg_r.chooser_index_bits <= 4'd14;
      cfg_r.gshare_index_bits  <= 4'd14;
      cfg_r.history_bits       <= 4'd8;
      cfg_r.bimodal_index_bits <= 4'd14;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:         cfg_r.mode               <= cfg_wdata[1:0];
        CFG_CHOOSER_BITS: cfg_r.chooser_index_bits <= cfg_wdata;
        CFG_GSHARE_BITS:  cfg_r.gshare_index_bits  <= cfg_wdata;
        CFG_HISTORY_BITS: cfg_r.history_bits       <= cfg_wdata;
        CFG_BIMODAL_BITS: cfg_r.bimodal_index_bits <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // front end -> queue
  logic          f_push, q_full, q_not_empty, q_pop, clr_busy;
  hbp_ctl_t      f_ctl, q_ctl;
  logic [CB-1:0] f_ci, q_ci;
  logic [GB-1:0] f_gi, q_gi;
  logic [BB-1:0] f_bi, q_bi;
  logic [QW-1:0] q_wdata, q_rdata;

  hbp_front #(.CB(CB), .GB(GB), .BB(BB)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .q_full   (q_full),
    .clr_busy (clr_busy),
    .push     (f_push),
    .ctl      (f_ctl),
    .ci       (f_ci),
    .gi       (f_gi),
    .bi       (f_bi)
  );

  assign q_wdata = {f_ctl, f_ci, f_gi, f_bi};

  hbp_queue #(.W(QW), .DEPTH(QDEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .wdata     (q_wdata),
    .pop       (q_pop),
    .rdata     (q_rdata),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  assign q_ctl = hbp_ctl_t'(q_rdata[QW-1 -: CTL_W]);
  assign q_ci  = q_rdata[GB+BB +: CB];
  assign q_gi  = q_rdata[BB +: GB];
  assign q_bi  = q_rdata[0 +: BB];

  hbp_back #(.CB(CB), .GB(GB), .BB(BB)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_not_empty),
    .q_ctl     (q_ctl),
    .q_ci      (q_ci),
    .q_gi      (q_gi),
    .q_bi      (q_bi),
    .q_pop     (q_pop),
    .clr_busy  (clr_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import hbp_pkg::*;

  localparam int unsigned TBL_BITS    = 14;
  localparam int unsigned TBL_DEPTH   = 1 << TBL_BITS;
  localparam int unsigned POOL_N      = 16;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned N_PHASES    = 6;
  // codes the package leaves unnamed
  localparam logic [1:0] TSEL_NONE    = 2'd3;  // no table: reads back 0
  localparam logic [1:0] MODE_ALT     = 2'd3;  // behaves as hybrid

  // Predictor copy plus the queue of result words it expects.
  class bp_scoreboard;
    bit [1:0]        chs_tbl[TBL_DEPTH];
    bit [2:0]        gsh_tbl[TBL_DEPTH];
    bit [2:0]        bim_tbl[TBL_DEPTH];
    bit [HIST_W-1:0] hist;
    bit [31:0]       branch_cnt;
    bit [31:0]       miss_cnt;
    bit [1:0]        mode;
    bit [3:0]        chs_bits, gsh_bits, hist_bits, bim_bits;
    hbp_out_t        due_q[$];
    int unsigned     errors, n_branch, n_read, n_miss;

    function new();
      foreach (chs_tbl[i]) chs_tbl[i] = CHS_INIT;
      foreach (gsh_tbl[i]) gsh_tbl[i] = CTR_INIT;
      foreach (bim_tbl[i]) bim_tbl[i] = CTR_INIT;
      hist       = '0;
      branch_cnt = '0;
      miss_cnt   = '0;
      mode       = MODE_HYBRID;
      chs_bits   = 4'd14;
      gsh_bits   = 4'd14;
      hist_bits  = 4'd8;
      bim_bits   = 4'd14;
      errors     = 0;
      n_branch   = 0;
      n_read     = 0;
      n_miss     = 0;
    endfunction

    // width 0 acts as 1, anything past the table size acts as the table size
    function int unsigned eff_bits(bit [3:0] v);
      if (v == 0) return 1;
      if (v > TBL_BITS) return TBL_BITS;
      return v;
    endfunction

    function bit [31:0] lo_mask(int unsigned b);
      return (32'd1 << b) - 32'd1;
    endfunction

    function bit [2:0] train(bit [2:0] c, bit t);
      if (t) return (c == 3'd7) ? c : c + 3'd1;
      return (c == 3'd0) ? c : c - 3'd1;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        CFG_MODE:         mode      = v[1:0];
        CFG_CHOOSER_BITS: chs_bits  = v;
        CFG_GSHARE_BITS:  gsh_bits  = v;
        CFG_HISTORY_BITS: hist_bits = v;
        CFG_BIMODAL_BITS: bim_bits  = v;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return due_q.size();
    endfunction

    function void note_word(hbp_in_t w);
      hbp_out_t    e;
      int unsigned k, m1, m2, n;
      bit [31:0]   waddr, hmask, gi, bi, ci, h;
      bit          gp, bp, gc, bc;
      e = '0;
      if (w.req_type == REQ_READ) begin
        case (w.table_select)
          TSEL_CHOOSER: e.read_value = {1'b0, chs_tbl[w.entry_index]};
          TSEL_GSHARE:  e.read_value = gsh_tbl[w.entry_index];
          TSEL_BIMODAL: e.read_value = bim_tbl[w.entry_index];
          default:      e.read_value = '0;
        endcase
        n_read++;
      end else begin
        k     = eff_bits(chs_bits);
        m1    = eff_bits(gsh_bits);
        m2    = eff_bits(bim_bits);
        n     = (hist_bits > m1) ? m1 : hist_bits;
        waddr = {2'b00, w.pc[31:2]};
        hmask = lo_mask(n);
        gi    = ((waddr & lo_mask(m1)) ^ (32'(hist) & hmask)) & (TBL_DEPTH - 1);
        bi    = waddr & lo_mask(m2);
        ci    = waddr & lo_mask(k);
        gp    = gsh_tbl[gi] >= 3'd4;
        bp    = bim_tbl[bi] >= 3'd4;
        if (mode == MODE_BIMODAL) e.used_gshare = 1'b0;
        else if (mode == MODE_GSHARE) e.used_gshare = 1'b1;
        else e.used_gshare = chs_tbl[ci] >= 2'd2;
        e.pred_taken   = e.used_gshare ? gp : bp;
        e.mispredicted = e.pred_taken != w.taken;
        // only the counter that made the call learns
        if (e.used_gshare) gsh_tbl[gi] = train(gsh_tbl[gi], w.taken);
        else bim_tbl[bi] = train(bim_tbl[bi], w.taken);
        if (mode != MODE_BIMODAL && mode != MODE_GSHARE) begin
          gc = gp == w.taken;
          bc = bp == w.taken;
          if (gc && !bc && chs_tbl[ci] != 2'd3) chs_tbl[ci]++;
          else if (!gc && bc && chs_tbl[ci] != 2'd0) chs_tbl[ci]--;
        end
        if (mode != MODE_BIMODAL) begin
          if (n == 0) begin
            hist = '0;
          end else begin
            h = (32'(hist) & hmask) >> 1;
            if (w.taken) h |= 32'd1 << (n - 1);
            hist = HIST_W'(h & hmask);
          end
        end
        if (branch_cnt != '1) branch_cnt++;
        if (e.mispredicted && miss_cnt != '1) miss_cnt++;
        n_branch++;
        if (e.mispredicted) n_miss++;
      end
      e.prediction_count = branch_cnt;
      e.mispredict_count = miss_cnt;
      due_q.push_back(e);
    endfunction

    function void cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_word(hbp_out_t r);
      hbp_out_t e;
      if (due_q.size() == 0) begin
        $error("result word with nothing outstanding");
        errors++;
        return;
      end
      e = due_q.pop_front();
      cmp_field("pred_taken", 32'(e.pred_taken), 32'(r.pred_taken));
      cmp_field("mispredicted", 32'(e.mispredicted), 32'(r.mispredicted));
      cmp_field("used_gshare", 32'(e.used_gshare), 32'(r.used_gshare));
      cmp_field("prediction_count", e.prediction_count, r.prediction_count);
      cmp_field("mispredict_count", e.mispredict_count, r.mispredict_count);
      cmp_field("read_value", 32'(e.read_value), 32'(r.read_value));
    endfunction
  endclass

  // every input known from time zero
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  hbp_in_t               in_data   = '0;
  logic                  out_stall = 1'b0;
  logic                  in_stall;
  logic                  out_valid;
  hbp_out_t              out_data;

  bp_scoreboard sb = new();

  // branch address pool: a few hot branches so counters and chooser saturate
  bit [31:0]   pool_pc[POOL_N];
  bit [1:0]    pool_kind[POOL_N];
  int unsigned pool_cnt[POOL_N];

  // receiver-side state; hold_requests is bumped by the main sequence
  int unsigned rx_cycle      = 0;
  int unsigned hold_left     = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_requests = 0;

  hybrid_branch_predictor_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  // Sampling happens on the edge, before any of this edge's updates land, so
  // config writes, accepted words and result words are all seen race-free.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.write_reg(cfg_index, cfg_wdata);
      if (in_valid && !in_stall) sb.note_word(in_data);
      if (out_valid && !out_stall) sb.check_word(out_data);
    end
  end

  // Receiver stall pattern: rotates through no stall, light, heavy and
  // alternate-cycle stalling; a long hold-off overrides it when requested so
  // the pipe backs up into in_stall.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_served != hold_requests) begin
      hold_served++;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      case ((rx_cycle / 48) % 4)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= rx_cycle[0];
      endcase
    end
    rx_cycle++;
  end

  // Ends a hung run; the timeout also has to cover the post-reset table sweep.
  initial begin
    #5_000_000;
    $display("hybrid_branch_predictor_unit regression: fail");
    $finish;
  end

  function automatic hbp_in_t branch_word(bit [31:0] pc, bit t);
    hbp_in_t w;
    w              = '0;
    w.req_type     = REQ_RESOLVE;
    w.pc           = pc;
    w.taken        = t;
    return w;
  endfunction

  function automatic hbp_in_t read_word(bit [1:0] sel, bit [13:0] idx);
    hbp_in_t w;
    w              = '0;
    w.req_type     = REQ_READ;
    w.table_select = sel;
    w.entry_index  = idx;
    return w;
  endfunction

  function automatic hbp_cfg_t mk_cfg(bit [1:0] md, bit [3:0] k, bit [3:0] g,
                                      bit [3:0] h, bit [3:0] b);
    hbp_cfg_t c;
    c.mode               = md;
    c.chooser_index_bits = k;
    c.gshare_index_bits  = g;
    c.history_bits       = h;
    c.bimodal_index_bits = b;
    return c;
  endfunction

  // Random word: mostly hot branches following their own pattern (always,
  // never, alternating, loop-exit), some random branches, some table reads.
  // Fields a request ignores are randomized too.
  function automatic hbp_in_t make_item();
    hbp_in_t     w;
    int unsigned r, s;
    w.req_type     = REQ_RESOLVE;
    w.pc           = $urandom();
    w.taken        = 1'($urandom_range(0, 1));
    w.table_select = 2'($urandom_range(0, 3));
    w.entry_index  = 14'($urandom_range(0, TBL_DEPTH - 1));
    r = $urandom_range(0, 99);
    if (r < 20) begin
      w.req_type = REQ_READ;
      // half the reads land on entries the hot branches train
      if ($urandom_range(0, 1)) w.entry_index = pool_pc[$urandom_range(0, POOL_N - 1)][15:2];
    end else if (r < 90) begin
      s    = $urandom_range(0, POOL_N - 1);
      w.pc = pool_pc[s];
      case (pool_kind[s])
        2'd0:    w.taken = 1'b1;
        2'd1:    w.taken = 1'b0;
        2'd2:    w.taken = pool_cnt[s][0];
        default: w.taken = (pool_cnt[s] % 4) != 3;
      endcase
      if ($urandom_range(0, 9) == 0) w.taken = ~w.taken;
      pool_cnt[s]++;
    end
    return w;
  endfunction

  task automatic new_pool();
    foreach (pool_pc[i]) begin
      pool_pc[i]   = $urandom();
      pool_kind[i] = 2'($urandom_range(0, 3));
      pool_cnt[i]  = 0;
    end
  endtask

  // Offer one word and hold it until taken. valid stays up into the next word.
  task automatic send_word(hbp_in_t w);
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic idle(int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Wait until every expected result word is back, plus pipe latency margin.
  // The first edge lets the scoreboard note the last accepted word.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Five back-to-back register writes; the enable drops only after the last.
  task automatic apply_setting(hbp_cfg_t c);
    logic [CFG_IDX_W-1:0]  idx[5];
    logic [CFG_DATA_W-1:0] val[5];
    idx = '{CFG_MODE, CFG_CHOOSER_BITS, CFG_GSHARE_BITS, CFG_HISTORY_BITS, CFG_BIMODAL_BITS};
    val = '{{2'b00, c.mode}, c.chooser_index_bits, c.gshare_index_bits,
            c.history_bits, c.bimodal_index_bits};
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Bursts of random length with random gaps; every other run of 32 words
  // goes back to back.
  task automatic run_random(int unsigned count);
    int unsigned sent, burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        if (sent < count) begin
          send_word(make_item());
          sent++;
        end
      end
      if ((sent % 64) >= 32 && $urandom_range(0, 3) != 0) idle($urandom_range(1, 6));
    end
  endtask

  // Reset-state reads, the address extremes, counter saturation both ways and
  // the empty table select.
  task automatic run_directed();
    send_word(read_word(TSEL_CHOOSER, 14'h0000));
    send_word(read_word(TSEL_GSHARE, 14'h3FFF));
    send_word(read_word(TSEL_BIMODAL, 14'h2AAA));
    send_word(read_word(TSEL_NONE, 14'h1555));
    repeat (5) send_word(branch_word(32'hFFFF_FFFF, 1'b1));
    repeat (6) send_word(branch_word(32'h0000_0000, 1'b0));
    repeat (2) send_word(branch_word(32'h0000_0000, 1'b1));
    send_word(read_word(TSEL_BIMODAL, 14'h3FFF));
    send_word(read_word(TSEL_BIMODAL, 14'h0000));
    send_word(read_word(TSEL_CHOOSER, 14'h3FFF));
    send_word(read_word(TSEL_GSHARE, 14'h0000));
    drain();
  endtask

  // Main sequence: reset, then one phase per register setting. Phases walk
  // all mode codes, index widths 0/1/14/15 and history 0, 14, 15 and past
  // the gshare width.
  initial begin
    hbp_cfg_t    phase_cfg[N_PHASES];
    int unsigned phase_items[N_PHASES];
    phase_cfg[0]   = mk_cfg(MODE_HYBRID, 4'd14, 4'd14, 4'd8, 4'd14);
    phase_cfg[1]   = mk_cfg(MODE_BIMODAL, 4'd1, 4'd1, 4'd0, 4'd1);
    phase_cfg[2]   = mk_cfg(MODE_GSHARE, 4'd14, 4'd4, 4'd15, 4'd3);
    phase_cfg[3]   = mk_cfg(MODE_ALT, 4'd0, 4'd15, 4'd14, 4'd15);
    phase_cfg[4]   = mk_cfg(MODE_HYBRID, 4'd3, 4'd6, 4'd6, 4'd5);
    phase_cfg[5]   = mk_cfg(MODE_HYBRID, 4'd0, 4'd0, 4'd0, 4'd0);
    phase_items    = '{60, 50, 50, 60, 80, 100};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < N_PHASES; p++) begin
      if (p == N_PHASES - 1) begin
        phase_cfg[p] = mk_cfg(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                              4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                              4'($urandom_range(0, 15)));
      end
      apply_setting(phase_cfg[p]);
      new_pool();
      if (p == 0) run_directed();
      if (p == 4) begin
        // long receiver hold-off while words keep coming, then a full drain
        hold_requests++;
        run_random(phase_items[p] / 2);
        drain();
        run_random(phase_items[p] - phase_items[p] / 2);
      end else begin
        run_random(phase_items[p]);
      end
      drain();
    end

    repeat (10) @(posedge clk);
    $display("run covered %0d branch words and %0d table reads, %0d mispredicted,",
             sb.n_branch, sb.n_read, sb.n_miss);
    $display("over %0d register settings including every mode code and width extreme",
             N_PHASES);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("hybrid_branch_predictor_unit regression: pass");
    end else begin
      $display("hybrid_branch_predictor_unit regression: fail");
    end
    $finish;
  end

endmodule
